// ===== sv/pwlc_pkg.sv =====
// Shared widths, codes and controller/datapath handshake types of the calibrator.
package pwlc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OP_W   = 2;
   localparam int unsigned PROF_W = 3;
   localparam int unsigned CHAN_W = 3;
   localparam int unsigned STAT_W = 3;

   // Opcodes. The unused fourth code behaves as a convert.
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd1;
   localparam logic [OP_W-1:0] OP_CONVERT = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_CONVERTED   = 3'd0;
   localparam logic [STAT_W-1:0] ST_PASSTHROUGH = 3'd1;
   localparam logic [STAT_W-1:0] ST_STORED      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL        = 3'd3;
   localparam logic [STAT_W-1:0] ST_CLEARED     = 3'd4;

   // The divider retires one quotient bit per cycle.
   localparam int unsigned DIV_STEPS = DATA_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_PASS,
      RES_REF_CUR,
      RES_CLAMP,
      RES_Y1,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic              capture;
      logic              pt_write;
      logic              clear;
      logic              idx_clr;
      logic              idx_inc;
      logic              mem_rd;
      logic              first_save;
      logic              prev_save;
      logic              seg_save;
      logic              mul;
      logic              div_start;
      logic              res_load;
      res_sel_type       res_sel;
      logic [STAT_W-1:0] res_status;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            in_range;
      logic            cnt_zero;
      logic            cnt_one;
      logic            cnt_full;
      logic            idx_first;
      logic            idx_last;
      logic            hit;
      logic            span_zero;
      logic            div_done;
   } stat_type;

endpackage

// ===== sv/pwlc_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface pwlc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pwlc_pkg::OP_W-1:0]     opcode;
   logic        [pwlc_pkg::PROF_W-1:0]   profile;
   logic        [pwlc_pkg::CHAN_W-1:0]   channel;
   logic signed [pwlc_pkg::DATA_W-1:0]   raw_sample;
   logic signed [pwlc_pkg::DATA_W-1:0]   ref_value;

   modport source (output valid, opcode, profile, channel, raw_sample, ref_value,
                   input ready);
   modport sink (input valid, opcode, profile, channel, raw_sample, ref_value,
                 output ready);
endinterface

interface pwlc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pwlc_pkg::DATA_W-1:0]   calibrated;
   logic        [pwlc_pkg::STAT_W-1:0]   status;

   modport source (output valid, calibrated, status, input ready);
   modport sink (input valid, calibrated, status, output ready);
endinterface

// ===== sv/pwlc_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients that fit one word.
module pwlc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [2*pwlc_pkg::DATA_W-1:0]       dividend,
   input  logic [pwlc_pkg::DATA_W-1:0]         divisor,
   output logic                                done,
   output logic [pwlc_pkg::DATA_W-1:0]         quotient
);
   localparam int unsigned W = pwlc_pkg::DATA_W;

   logic                           busy_ff;
   logic                           done_ff;
   logic [pwlc_pkg::STEP_W-1:0]    step_ff;
   logic [W-1:0]                   rem_ff, rem_in;
   logic [W-1:0]                   quo_ff, quo_in;
   logic [W-1:0]                   div_ff;
   logic [W:0]                     trial;
   logic [W:0]                     diff;
   logic                           fits;

   // The caller guarantees the upper dividend word is below the divisor,
   // so the partial remainder always fits one word.
   always_comb begin
      trial  = {rem_ff, quo_ff[W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[W-1:0] : trial[W-1:0];
      quo_in = {quo_ff[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == pwlc_pkg::STEP_W'(pwlc_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[2*W-1:W];
         quo_ff <= dividend[W-1:0];
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/pwlc_dp.sv =====
// Datapath: point tables, segment compare, multiplier, divider and result registers.
module pwlc_dp #(
   parameter int PROFILES   = 8,
   parameter int CHANNELS   = 7,
   parameter int MAX_POINTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pwlc_pkg::cmd_type                    cmd,
   output pwlc_pkg::stat_type                   stat,
   input  logic        [pwlc_pkg::OP_W-1:0]     req_opcode,
   input  logic        [pwlc_pkg::PROF_W-1:0]   req_profile,
   input  logic        [pwlc_pkg::CHAN_W-1:0]   req_channel,
   input  logic signed [pwlc_pkg::DATA_W-1:0]   req_raw_sample,
   input  logic signed [pwlc_pkg::DATA_W-1:0]   req_ref_value,
   output logic signed [pwlc_pkg::DATA_W-1:0]   out_calibrated,
   output logic        [pwlc_pkg::STAT_W-1:0]   out_status
);
   localparam int W      = pwlc_pkg::DATA_W;
   localparam int TABLES = PROFILES * CHANNELS;
   localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int PT_W   = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int DEPTH  = TABLES * MAX_POINTS;
   localparam int ADDR_W = $clog2(DEPTH);

   // Captured request.
   logic        [pwlc_pkg::OP_W-1:0]   op_ff;
   logic        [pwlc_pkg::PROF_W-1:0] prof_ff;
   logic signed [W-1:0]                x_ff;
   logic signed [W-1:0]                yin_ff;
   logic                               in_range_ff, in_range_in;
   logic        [TBL_W-1:0]            tbl_ff, tbl_in;
   logic        [ADDR_W-1:0]           base_ff, base_in;

   // Point counts live in a small memory; a per-table valid bit stands in for
   // the reset and clear values of zero.
   logic        [CNT_W-1:0]            cnt_mem [TABLES];
   logic        [CNT_W-1:0]            cnt_rd_ff;
   logic                               tbl_vld_ff [TABLES];
   logic        [CNT_W-1:0]            cnt_eff;

   logic signed [W-1:0]                raw_mem [DEPTH];
   logic signed [W-1:0]                ref_mem [DEPTH];
   logic signed [W-1:0]                raw_rd_ff, ref_rd_ff;
   logic        [PT_W-1:0]             idx_ff;
   logic        [ADDR_W-1:0]           rd_addr, wr_addr;

   logic signed [W-1:0]                first_raw_ff, first_ref_ff;
   logic signed [W-1:0]                prev_raw_ff, prev_ref_ff;

   // Segment arithmetic.
   logic        [W:0]                  dy_in, off_full, span_full;
   logic signed [W-1:0]                y1_ff;
   logic                               neg_ff;
   logic        [W-1:0]                mag_ff, mag_in;
   logic        [W-1:0]                off_ff, span_ff;
   logic        [2*W-1:0]              prod_ff, prod_in;
   logic                               div_done;
   logic        [W-1:0]                quo;
   logic        [W:0]                  interp_in;

   logic signed [W-1:0]                res_ff, res_in;
   logic        [pwlc_pkg::STAT_W-1:0] res_stat_ff;
   logic signed [W-1:0]                out_cal_ff;
   logic        [pwlc_pkg::STAT_W-1:0] out_stat_ff;

   always_comb begin
      in_range_in = (int'(req_profile) < PROFILES) && (int'(req_channel) < CHANNELS);
      tbl_in      = in_range_in ?
                    TBL_W'(int'(req_profile) * CHANNELS + int'(req_channel)) : '0;
      base_in     = ADDR_W'(int'(tbl_in) * MAX_POINTS);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_opcode;
         prof_ff     <= req_profile;
         x_ff        <= req_raw_sample;
         yin_ff      <= req_ref_value;
         in_range_ff <= in_range_in;
         tbl_ff      <= tbl_in;
         base_ff     <= base_in;
      end
   end

   assign cnt_eff = tbl_vld_ff[tbl_ff] ? cnt_rd_ff : '0;
   assign rd_addr = base_ff + ADDR_W'(idx_ff);
   assign wr_addr = base_ff + ADDR_W'(cnt_eff[PT_W-1:0]);

   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[tbl_ff];
      if (cmd.pt_write) begin
         cnt_mem[tbl_ff] <= cnt_eff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TABLES; t++) begin
            tbl_vld_ff[t] <= 1'b0;
         end
      end else begin
         if (cmd.pt_write) begin
            tbl_vld_ff[tbl_ff] <= 1'b1;
         end
         if (cmd.clear) begin
            for (int t = 0; t < TABLES; t++) begin
               if (int'(prof_ff) == t / CHANNELS) begin
                  tbl_vld_ff[t] <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pt_write) begin
         raw_mem[wr_addr] <= x_ff;
         ref_mem[wr_addr] <= yin_ff;
      end
      if (cmd.mem_rd) begin
         raw_rd_ff <= raw_mem[rd_addr];
         ref_rd_ff <= ref_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.first_save) begin
         first_raw_ff <= raw_rd_ff;
         first_ref_ff <= ref_rd_ff;
      end
      if (cmd.first_save || cmd.prev_save) begin
         prev_raw_ff <= raw_rd_ff;
         prev_ref_ff <= ref_rd_ff;
      end
   end

   // The hit segment runs from the previous point to the one just read.
   always_comb begin
      dy_in     = {ref_rd_ff[W-1], ref_rd_ff} - {prev_ref_ff[W-1], prev_ref_ff};
      off_full  = {x_ff[W-1], x_ff} - {prev_raw_ff[W-1], prev_raw_ff};
      span_full = {raw_rd_ff[W-1], raw_rd_ff} - {prev_raw_ff[W-1], prev_raw_ff};
      mag_in    = dy_in[W] ? W'(-dy_in) : dy_in[W-1:0];
      prod_in   = mag_ff * off_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.seg_save) begin
         y1_ff   <= prev_ref_ff;
         neg_ff  <= dy_in[W];
         mag_ff  <= mag_in;
         off_ff  <= off_full[W-1:0];
         span_ff <= span_full[W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   pwlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (quo)
   );

   // The quotient never exceeds the reference step, so the sum stays in range.
   assign interp_in = neg_ff ? ({y1_ff[W-1], y1_ff} - {1'b0, quo})
                             : ({y1_ff[W-1], y1_ff} + {1'b0, quo});

   always_comb begin
      case (cmd.res_sel)
         pwlc_pkg::RES_PASS:    res_in = x_ff;
         pwlc_pkg::RES_REF_CUR: res_in = ref_rd_ff;
         pwlc_pkg::RES_CLAMP:   res_in = (x_ff < first_raw_ff) ? first_ref_ff : ref_rd_ff;
         pwlc_pkg::RES_Y1:      res_in = y1_ff;
         pwlc_pkg::RES_INTERP:  res_in = interp_in[W-1:0];
         default:               res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_ff      <= res_in;
         res_stat_ff <= cmd.res_status;
      end
      if (cmd.out_load) begin
         out_cal_ff  <= res_ff;
         out_stat_ff <= res_stat_ff;
      end
   end

   assign out_calibrated = out_cal_ff;
   assign out_status     = out_stat_ff;

   always_comb begin
      stat.opcode    = op_ff;
      stat.in_range  = in_range_ff;
      stat.cnt_zero  = !in_range_ff || (cnt_eff == '0);
      stat.cnt_one   = (cnt_eff == CNT_W'(1));
      stat.cnt_full  = (cnt_eff == CNT_W'(MAX_POINTS));
      stat.idx_first = (idx_ff == '0);
      stat.idx_last  = ((CNT_W'(idx_ff) + 1'b1) == cnt_eff);
      stat.hit       = (x_ff >= prev_raw_ff) && (x_ff <= raw_rd_ff);
      stat.span_zero = (span_ff == '0);
      stat.div_done  = div_done;
   end

endmodule

// ===== sv/pwlc_ctrl.sv =====
// Controller: sequences append, clear and the segment scan, and owns the response valid.
module pwlc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pwlc_pkg::stat_type   stat,
   output pwlc_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE,
      S_COUNT,
      S_DECIDE,
      S_READ,
      S_CMP,
      S_MUL,
      S_DIVGO,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_COUNT;
            end
         end
         S_COUNT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            unique case (stat.opcode)
               pwlc_pkg::OP_APPEND: begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = pwlc_pkg::RES_ZERO;
                  if (stat.in_range && !stat.cnt_full) begin
                     cmd.pt_write   = 1'b1;
                     cmd.res_status = pwlc_pkg::ST_STORED;
                  end else begin
                     cmd.res_status = pwlc_pkg::ST_FULL;
                  end
                  state_in = S_DONE;
               end
               pwlc_pkg::OP_CLEAR: begin
                  cmd.clear      = 1'b1;
                  cmd.res_load   = 1'b1;
                  cmd.res_sel    = pwlc_pkg::RES_ZERO;
                  cmd.res_status = pwlc_pkg::ST_CLEARED;
                  state_in       = S_DONE;
               end
               default: begin
                  if (stat.cnt_zero) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_sel    = pwlc_pkg::RES_PASS;
                     cmd.res_status = pwlc_pkg::ST_PASSTHROUGH;
                     state_in       = S_DONE;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_READ;
                  end
               end
            endcase
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            if (stat.cnt_one) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pwlc_pkg::RES_REF_CUR;
               cmd.res_status = pwlc_pkg::ST_CONVERTED;
               state_in       = S_DONE;
            end else if (stat.idx_first) begin
               cmd.first_save = 1'b1;
               cmd.idx_inc    = 1'b1;
               state_in       = S_READ;
            end else if (stat.hit) begin
               cmd.seg_save = 1'b1;
               state_in     = S_MUL;
            end else if (stat.idx_last) begin
               // No segment holds the sample: clamp to the nearer end.
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pwlc_pkg::RES_CLAMP;
               cmd.res_status = pwlc_pkg::ST_CONVERTED;
               state_in       = S_DONE;
            end else begin
               cmd.prev_save = 1'b1;
               cmd.idx_inc   = 1'b1;
               state_in      = S_READ;
            end
         end
         S_MUL: begin
            if (stat.span_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pwlc_pkg::RES_Y1;
               cmd.res_status = pwlc_pkg::ST_CONVERTED;
               state_in       = S_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = pwlc_pkg::RES_INTERP;
               cmd.res_status = pwlc_pkg::ST_CONVERTED;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/piecewise_linear_sensor_calibrator.sv =====
// Piecewise-linear sensor calibrator: one table of (raw, reference) points per profile and
// channel; append, clear and convert items each return one response item. Items are taken
// one at a time. A convert on an empty table passes the sample through, and one on a
// one-point table returns that point's reference; otherwise the point memory is read
// point by point until the matching segment is found, the result is clamped to an end
// when no segment holds the sample, and an interpolation adds a multiply step and a
// bit-serial divide. A response waiting in the output register does not stop the next
// item from being taken.
module piecewise_linear_sensor_calibrator #(
   parameter int PROFILES   = 8,
   parameter int CHANNELS   = 7,
   parameter int MAX_POINTS = 16
) (
   input  logic           clock,
   input  logic           reset,
   pwlc_req_if.sink       req_chan,
   pwlc_rsp_if.source     rsp_chan
);
   pwlc_pkg::cmd_type  cmd;
   pwlc_pkg::stat_type stat;

   pwlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwlc_dp #(
      .PROFILES   (PROFILES),
      .CHANNELS   (CHANNELS),
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_chan.opcode),
      .req_profile    (req_chan.profile),
      .req_channel    (req_chan.channel),
      .req_raw_sample (req_chan.raw_sample),
      .req_ref_value  (req_chan.ref_value),
      .out_calibrated (rsp_chan.calibrated),
      .out_status     (rsp_chan.status)
   );

endmodule

// ===== sv/pwlc_checker.sv =====
// Port-level checks of the calibrator and the bind that attaches them.
module pwlc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [pwlc_pkg::DATA_W-1:0]       rsp_calibrated,
   input logic [pwlc_pkg::STAT_W-1:0]       rsp_status
);
   // A stalled response item keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_calibrated) && $stable(rsp_status))
      else $error("response item changed while stalled");

   // Items are worked one at a time, so the request side closes after a take.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // Only a convert carries a value.
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pwlc_pkg::ST_STORED || rsp_status == pwlc_pkg::ST_FULL ||
                    rsp_status == pwlc_pkg::ST_CLEARED) |-> rsp_calibrated == '0)
      else $error("non-convert response with nonzero value");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind piecewise_linear_sensor_calibrator pwlc_checker u_pwlc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_calibrated (rsp_chan.calibrated),
   .rsp_status     (rsp_chan.status)
);
